### src/tcr_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and character class functions for the token class recognizer.
package tcr_pkg;

	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	localparam logic [1:0] OP_BEGIN     = 2'd0;
	localparam logic [1:0] OP_NEXT      = 2'd1;
	localparam logic [1:0] OP_END       = 2'd2;
	localparam logic [1:0] OP_BEGIN_END = 2'd3;

	localparam logic [3:0] K_OPT_BLANK  = 4'd0;
	localparam logic [3:0] K_BLANK      = 4'd1;
	localparam logic [3:0] K_LINE_END   = 4'd2;
	localparam logic [3:0] K_ANY        = 4'd3;
	localparam logic [3:0] K_SEMI       = 4'd4;
	localparam logic [3:0] K_SLASHSLASH = 4'd5;
	localparam logic [3:0] K_BLOCK      = 4'd6;
	localparam logic [3:0] K_IDENT      = 4'd7;
	localparam logic [3:0] K_IDENT_H    = 4'd8;
	localparam logic [3:0] K_IDENT_U    = 4'd9;
	localparam logic [3:0] K_DEC        = 4'd10;
	localparam logic [3:0] K_HEX        = 4'd11;
	localparam logic [3:0] K_QUOTE_S    = 4'd12;
	localparam logic [3:0] K_QUOTE_D    = 4'd13;
	localparam logic [3:0] K_QUOTE_ANY  = 4'd14;

	localparam logic [4:0] PH_IDLE   = 5'd0;
	localparam logic [4:0] PH_BLANK  = 5'd1;
	localparam logic [4:0] PH_PRINT  = 5'd2;
	localparam logic [4:0] PH_ID     = 5'd3;
	localparam logic [4:0] PH_IDH    = 5'd4;
	localparam logic [4:0] PH_IDU    = 5'd5;
	localparam logic [4:0] PH_DEC    = 5'd6;
	localparam logic [4:0] PH_HEXRUN = 5'd7;
	localparam logic [4:0] PH_CR     = 5'd8;
	localparam logic [4:0] PH_CPP1   = 5'd9;
	localparam logic [4:0] PH_BLK1   = 5'd10;
	localparam logic [4:0] PH_BLKB   = 5'd11;
	localparam logic [4:0] PH_BLKS   = 5'd12;
	localparam logic [4:0] PH_HEX0   = 5'd13;
	localparam logic [4:0] PH_HEXX   = 5'd14;
	localparam logic [4:0] PH_QS     = 5'd15;
	localparam logic [4:0] PH_QD     = 5'd16;

	localparam logic [7:0] CH_TAB    = 8'd9;
	localparam logic [7:0] CH_LF     = 8'd10;
	localparam logic [7:0] CH_CR     = 8'd13;
	localparam logic [7:0] CH_SP     = 8'd32;
	localparam logic [7:0] CH_DEL    = 8'd127;
	localparam logic [7:0] CH_STAR   = 8'd42;
	localparam logic [7:0] CH_SLASH  = 8'd47;
	localparam logic [7:0] CH_SEMI   = 8'd59;
	localparam logic [7:0] CH_SQUOTE = 8'd39;
	localparam logic [7:0] CH_DQUOTE = 8'd34;
	localparam logic [7:0] CH_X      = 8'd120;
	localparam logic [7:0] CH_ZERO   = 8'd48;
	localparam logic [7:0] CH_HYPHEN = 8'd45;
	localparam logic [7:0] CH_UNDER  = 8'd95;

	typedef struct packed {
		logic [4:0]  phase;
		logic [15:0] count;
		logic        sat;
	} state_t;

	typedef struct packed {
		logic        matched;
		logic [15:0] length;
		logic        overflow;
	} result_t;

	typedef struct packed {
		state_t  nxt;
		logic    fire;
		result_t res;
	} step_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_TAB) || (c == CH_SP);
	endfunction

	function automatic logic is_print(input logic [7:0] c);
		return (c == CH_TAB) || ((c >= CH_SP) && (c <= CH_DEL));
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'd48) && (c <= 8'd57);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_alpha(c) || is_digit(c);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || ((c >= 8'd65) && (c <= 8'd70)) ||
			((c >= 8'd97) && (c <= 8'd102));
	endfunction

	function automatic logic is_cbody(input logic [7:0] c);
		return is_print(c) || (c == CH_LF) || (c == CH_CR);
	endfunction

endpackage

### src/tcr_step.sv
`timescale 1ns / 1ps
// Next-state and result logic for one character step of the recognizer.
module tcr_step (
	input  logic [1:0]     op,
	input  logic [7:0]     ch,
	input  logic [3:0]     kind,
	input  tcr_pkg::state_t cur,
	output tcr_pkg::step_t step
);

	logic [4:0]  ph;
	logic [15:0] cnt;
	logic        sat;
	logic        bmp;
	logic        fin;
	logic        hit;

	always_comb begin
		ph  = cur.phase;
		cnt = cur.count;
		sat = cur.sat;
		bmp = 1'b0;
		fin = 1'b0;
		hit = 1'b0;
		unique case (op)
			tcr_pkg::OP_BEGIN: begin
				cnt = '0;
				sat = 1'b0;
				ph  = tcr_pkg::PH_IDLE;
				unique case (kind)
					tcr_pkg::K_OPT_BLANK: begin
						if (tcr_pkg::is_blank(ch)) begin
							ph = tcr_pkg::PH_BLANK; cnt = 16'd1;
						end else begin
							fin = 1'b1; hit = 1'b1;
						end
					end
					tcr_pkg::K_BLANK: begin
						if (tcr_pkg::is_blank(ch)) begin
							ph = tcr_pkg::PH_BLANK; cnt = 16'd1;
						end else fin = 1'b1;
					end
					tcr_pkg::K_LINE_END: begin
						if (ch == tcr_pkg::CH_LF) begin
							cnt = 16'd1; fin = 1'b1; hit = 1'b1;
						end else if (ch == tcr_pkg::CH_CR) begin
							ph = tcr_pkg::PH_CR; cnt = 16'd1;
						end else fin = 1'b1;
					end
					tcr_pkg::K_ANY: begin
						if (tcr_pkg::is_print(ch)) begin
							ph = tcr_pkg::PH_PRINT; cnt = 16'd1;
						end else begin
							fin = 1'b1; hit = 1'b1;
						end
					end
					tcr_pkg::K_SEMI: begin
						if (ch == tcr_pkg::CH_SEMI) begin
							ph = tcr_pkg::PH_PRINT; cnt = 16'd1;
						end else fin = 1'b1;
					end
					tcr_pkg::K_SLASHSLASH: begin
						if (ch == tcr_pkg::CH_SLASH) begin
							ph = tcr_pkg::PH_CPP1; cnt = 16'd1;
						end else fin = 1'b1;
					end
					tcr_pkg::K_BLOCK: begin
						if (ch == tcr_pkg::CH_SLASH) begin
							ph = tcr_pkg::PH_BLK1; cnt = 16'd1;
						end else fin = 1'b1;
					end
					tcr_pkg::K_IDENT: begin
						if (tcr_pkg::is_alpha(ch)) begin
							ph = tcr_pkg::PH_ID; cnt = 16'd1;
						end else fin = 1'b1;
					end
					tcr_pkg::K_IDENT_H: begin
						if (tcr_pkg::is_alpha(ch)) begin
							ph = tcr_pkg::PH_IDH; cnt = 16'd1;
						end else fin = 1'b1;
					end
					tcr_pkg::K_IDENT_U: begin
						if (tcr_pkg::is_alpha(ch)) begin
							ph = tcr_pkg::PH_IDU; cnt = 16'd1;
						end else fin = 1'b1;
					end
					tcr_pkg::K_DEC: begin
						if (tcr_pkg::is_digit(ch)) begin
							ph = tcr_pkg::PH_DEC; cnt = 16'd1;
						end else fin = 1'b1;
					end
					tcr_pkg::K_HEX: begin
						if (ch == tcr_pkg::CH_ZERO) begin
							ph = tcr_pkg::PH_HEX0; cnt = 16'd1;
						end else fin = 1'b1;
					end
					tcr_pkg::K_QUOTE_S: begin
						if (ch == tcr_pkg::CH_SQUOTE) begin
							ph = tcr_pkg::PH_QS; cnt = 16'd1;
						end else fin = 1'b1;
					end
					tcr_pkg::K_QUOTE_D: begin
						if (ch == tcr_pkg::CH_DQUOTE) begin
							ph = tcr_pkg::PH_QD; cnt = 16'd1;
						end else fin = 1'b1;
					end
					tcr_pkg::K_QUOTE_ANY: begin
						if (ch == tcr_pkg::CH_SQUOTE) begin
							ph = tcr_pkg::PH_QS; cnt = 16'd1;
						end else if (ch == tcr_pkg::CH_DQUOTE) begin
							ph = tcr_pkg::PH_QD; cnt = 16'd1;
						end else fin = 1'b1;
					end
					default: fin = 1'b1;
				endcase
			end
			tcr_pkg::OP_NEXT: begin
				unique case (cur.phase) inside
					tcr_pkg::PH_IDLE: ;
					tcr_pkg::PH_BLANK: begin
						if (tcr_pkg::is_blank(ch)) bmp = 1'b1;
						else begin fin = 1'b1; hit = 1'b1; end
					end
					tcr_pkg::PH_PRINT: begin
						if (tcr_pkg::is_print(ch)) bmp = 1'b1;
						else begin fin = 1'b1; hit = 1'b1; end
					end
					tcr_pkg::PH_ID: begin
						if (tcr_pkg::is_alnum(ch)) bmp = 1'b1;
						else begin fin = 1'b1; hit = 1'b1; end
					end
					tcr_pkg::PH_IDH: begin
						if (tcr_pkg::is_alnum(ch) || ch == tcr_pkg::CH_HYPHEN) bmp = 1'b1;
						else begin fin = 1'b1; hit = 1'b1; end
					end
					tcr_pkg::PH_IDU: begin
						if (tcr_pkg::is_alnum(ch) || ch == tcr_pkg::CH_UNDER) bmp = 1'b1;
						else begin fin = 1'b1; hit = 1'b1; end
					end
					tcr_pkg::PH_DEC: begin
						if (tcr_pkg::is_digit(ch)) bmp = 1'b1;
						else begin fin = 1'b1; hit = 1'b1; end
					end
					tcr_pkg::PH_HEXRUN: begin
						if (tcr_pkg::is_hex(ch)) bmp = 1'b1;
						else begin fin = 1'b1; hit = 1'b1; end
					end
					tcr_pkg::PH_CR: begin
						bmp = (ch == tcr_pkg::CH_LF);
						fin = 1'b1;
						hit = 1'b1;
					end
					tcr_pkg::PH_CPP1: begin
						if (ch == tcr_pkg::CH_SLASH) begin
							bmp = 1'b1; ph = tcr_pkg::PH_PRINT;
						end else fin = 1'b1;
					end
					tcr_pkg::PH_BLK1: begin
						if (ch == tcr_pkg::CH_STAR) begin
							bmp = 1'b1; ph = tcr_pkg::PH_BLKB;
						end else fin = 1'b1;
					end
					tcr_pkg::PH_BLKB: begin
						if (ch == tcr_pkg::CH_STAR) begin
							bmp = 1'b1; ph = tcr_pkg::PH_BLKS;
						end else if (tcr_pkg::is_cbody(ch)) bmp = 1'b1;
						else fin = 1'b1;
					end
					tcr_pkg::PH_BLKS: begin
						if (ch == tcr_pkg::CH_SLASH) begin
							bmp = 1'b1; fin = 1'b1; hit = 1'b1;
						end else if (ch == tcr_pkg::CH_STAR) bmp = 1'b1;
						else if (tcr_pkg::is_cbody(ch)) begin
							bmp = 1'b1; ph = tcr_pkg::PH_BLKB;
						end else fin = 1'b1;
					end
					tcr_pkg::PH_HEX0: begin
						if (ch == tcr_pkg::CH_X) begin
							bmp = 1'b1; ph = tcr_pkg::PH_HEXX;
						end else fin = 1'b1;
					end
					tcr_pkg::PH_HEXX: begin
						if (tcr_pkg::is_hex(ch)) begin
							bmp = 1'b1; ph = tcr_pkg::PH_HEXRUN;
						end else fin = 1'b1;
					end
					tcr_pkg::PH_QS: begin
						if (ch == tcr_pkg::CH_SQUOTE) begin
							bmp = 1'b1; fin = 1'b1; hit = 1'b1;
						end else if (tcr_pkg::is_print(ch)) bmp = 1'b1;
						else fin = 1'b1;
					end
					tcr_pkg::PH_QD: begin
						if (ch == tcr_pkg::CH_DQUOTE) begin
							bmp = 1'b1; fin = 1'b1; hit = 1'b1;
						end else if (tcr_pkg::is_print(ch)) bmp = 1'b1;
						else fin = 1'b1;
					end
					default: ph = tcr_pkg::PH_IDLE;
				endcase
			end
			tcr_pkg::OP_END: begin
				if (cur.phase != tcr_pkg::PH_IDLE) begin
					fin = 1'b1;
					unique case (cur.phase) inside
						tcr_pkg::PH_BLANK, tcr_pkg::PH_PRINT, tcr_pkg::PH_ID,
						tcr_pkg::PH_IDH, tcr_pkg::PH_IDU, tcr_pkg::PH_DEC,
						tcr_pkg::PH_HEXRUN, tcr_pkg::PH_CR: hit = 1'b1;
						default: hit = 1'b0;
					endcase
				end
			end
			tcr_pkg::OP_BEGIN_END: begin
				cnt = '0;
				sat = 1'b0;
				fin = 1'b1;
				hit = (kind == tcr_pkg::K_OPT_BLANK) || (kind == tcr_pkg::K_ANY);
			end
			default: ;
		endcase
		if (bmp) begin
			if (cnt != tcr_pkg::LEN_MAX) cnt = cnt + 16'd1;
			else sat = 1'b1;
		end
		if (fin) ph = tcr_pkg::PH_IDLE;
	end

	assign step.nxt.phase     = ph;
	assign step.nxt.count     = cnt;
	assign step.nxt.sat       = sat;
	assign step.fire          = fin;
	assign step.res.matched   = hit;
	assign step.res.length    = hit ? cnt : 16'd0;
	assign step.res.overflow  = hit & sat;

endmodule

### src/token_class_recognizer_core.sv
`timescale 1ns / 1ps
// Top level of the token class recognizer: input register, recognizer state, result register.
// A character is registered in the input register, its result in the result register.
// Throughput: one character per cycle unless stalled; the state updates in a single pass.
// Only a held result on the output side stalls a character that produces a result.
// Reset (arst_n low, asynchronous) empties both registers, clears the state, sets class 0.
module token_class_recognizer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  ch,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        matched,
	output logic [15:0] length,
	output logic        overflow,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);

	logic             vld_s1;
	logic [1:0]       op_s1;
	logic [7:0]       ch_s1;
	logic             vld_s2;
	tcr_pkg::result_t res_s2;
	tcr_pkg::state_t  state_q;
	logic [3:0]       kind_q;
	tcr_pkg::step_t   step;
	logic             adv;
	logic             proc;

	tcr_step u_step (
		.op   (op_s1),
		.ch   (ch_s1),
		.kind (kind_q),
		.cur  (state_q),
		.step (step)
	);

	assign adv       = ~vld_s2 | ~res_stall;
	assign proc      = vld_s1 & (adv | ~step.fire);
	assign src_stall = vld_s1 & ~proc;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!src_stall) begin
			vld_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			op_s1 <= op;
			ch_s1 <= ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: tcr_pkg::PH_IDLE, count: 16'd0, sat: 1'b0};
		end else if (proc) begin
			state_q <= step.nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= tcr_pkg::K_OPT_BLANK;
		end else if (cfg_valid && cfg_ready) begin
			kind_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (proc && step.fire) begin
			vld_s2 <= 1'b1;
		end else if (adv) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && step.fire) begin
			res_s2 <= step.res;
		end
	end

	assign res_valid = vld_s2;
	assign matched   = res_s2.matched;
	assign length    = res_s2.length;
	assign overflow  = res_s2.overflow;

endmodule

### src/tcr_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the token class recognizer and its bind to the top level.
module tcr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        src_valid,
	input logic        src_stall,
	input logic        res_valid,
	input logic        res_stall,
	input logic        matched,
	input logic [15:0] length,
	input logic        overflow
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(matched) && $stable(length)
			&& $stable(overflow))
		else $error("stalled result changed");

	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !matched |-> length == 16'd0 && !overflow)
		else $error("no-match result carries length or overflow");

	a_ovf_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && overflow |-> length == tcr_pkg::LEN_MAX)
		else $error("overflow without saturated length");

	a_res_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(src_valid && !src_stall, 2))
		else $error("result without an input transfer");

endmodule

bind token_class_recognizer_core tcr_checker u_tcr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_valid (src_valid),
	.src_stall (src_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.matched   (matched),
	.length    (length),
	.overflow  (overflow)
);
